// ----- sv/gcdist_pkg.sv -----
package gcdist_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 31;
    localparam int XW           = 34;
    localparam int ZW           = 33;

    typedef logic signed [25:0]   ang_t;
    typedef logic signed [31:0]   q30s_t;
    typedef logic [30:0]          q30u_t;
    typedef logic signed [XW-1:0] cx_t;
    typedef logic signed [ZW-1:0] cz_t;

    typedef struct packed {
        cx_t x;
        cx_t y;
        cz_t z;
    } cordic_t;

    localparam logic [25:0] FULL_TURN    = 26'd47185920;
    localparam logic [25:0] QUARTER_TURN = 26'd11796480;
    localparam logic [24:0] DEG_TO_RAD   = 25'd18740330;
    localparam cx_t         CORDIC_GAIN  = 34'sd652032875;
    localparam q30s_t       ONE_Q30      = 32'sd1073741824;
    localparam logic [21:0] RADIUS_RESET = 22'd1630976;
    localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

    localparam int SINCOS_LAT = CORDIC_STEPS + 3;
    localparam int HAV_LAT    = 2;
    localparam int SQRT_LAT   = SQRT_STEPS;
    localparam int ATAN_LAT   = CORDIC_STEPS;
    // input stage + units + product stage + output stage
    localparam int PIPE_DEPTH = 1 + SINCOS_LAT + HAV_LAT + SQRT_LAT + ATAN_LAT + 2;

    // atan(2^-i) in Q30 radians
    function automatic cz_t atan_entry(input int i);
        cz_t v;
        case (i)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            default: v = cz_t'(33'sd1 <<< (30 - i));
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up
    function automatic q30s_t mulq(input q30s_t a, input q30s_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return q30s_t'(p >>> 30);
    endfunction

    function automatic q30s_t clamp_unit(input logic signed [34:0] v);
        q30s_t r;
        if (v > 35'sd1073741824) begin
            r = ONE_Q30;
        end
        else if (v < -35'sd1073741824) begin
            r = -ONE_Q30;
        end
        else begin
            r = q30s_t'(v);
        end
        return r;
    endfunction

endpackage

// ----- sv/gcdist_sincos.sv -----
module gcdist_sincos (
    input  logic                 clk,
    input  logic                 en,
    input  gcdist_pkg::ang_t     ang,
    output gcdist_pkg::q30s_t    sin_q,
    output gcdist_pkg::q30s_t    cos_q
);

    localparam int N = gcdist_pkg::CORDIC_STEPS;
    localparam logic [25:0] Q1 = gcdist_pkg::QUARTER_TURN;
    localparam logic [25:0] Q2 = 26'(Q1 * 2);
    localparam logic [25:0] Q3 = 26'(Q1 * 3);

    function automatic gcdist_pkg::cordic_t rot_step(input gcdist_pkg::cordic_t s,
                                                     input int i);
        gcdist_pkg::cordic_t o;
        if (s.z >= 0) begin
            o.x = s.x - (s.y >>> i);
            o.y = s.y + (s.x >>> i);
            o.z = s.z - gcdist_pkg::atan_entry(i);
        end
        else begin
            o.x = s.x + (s.y >>> i);
            o.y = s.y - (s.x >>> i);
            o.z = s.z + gcdist_pkg::atan_entry(i);
        end
        return o;
    endfunction

    logic [26:0]         wrap;
    logic [25:0]         turn;
    logic [1:0]          quad;
    logic [25:0]         base;
    logic [48:0]         zprod;
    logic signed [34:0]  sn;
    logic signed [34:0]  cn;
    logic signed [34:0]  xe;
    logic signed [34:0]  ye;

    logic [1:0]          q1_reg;
    logic [23:0]         rem1_reg;
    gcdist_pkg::cordic_t st_reg [0:N];
    logic [1:0]          q_reg  [0:N];
    gcdist_pkg::q30s_t   sin_reg;
    gcdist_pkg::q30s_t   cos_reg;

    // fold into one turn, then split into quadrant and remainder
    always_comb begin
        wrap = ang[25] ? 27'(ang) + 27'(gcdist_pkg::FULL_TURN) : 27'(ang);
        turn = wrap[25:0];
        if (turn >= Q3) begin
            quad = 2'd3;
            base = Q3;
        end
        else if (turn >= Q2) begin
            quad = 2'd2;
            base = Q2;
        end
        else if (turn >= Q1) begin
            quad = 2'd1;
            base = Q1;
        end
        else begin
            quad = 2'd0;
            base = 26'd0;
        end
        zprod = 49'(rem1_reg) * 49'(gcdist_pkg::DEG_TO_RAD) + 49'd65536;
    end

    always_comb begin
        xe = 35'(st_reg[N].x);
        ye = 35'(st_reg[N].y);
        case (q_reg[N])
            2'd0: begin sn = ye;  cn = xe;  end
            2'd1: begin sn = xe;  cn = -ye; end
            2'd2: begin sn = -ye; cn = -xe; end
            default: begin sn = -xe; cn = ye; end
        endcase
    end

    always_ff @(posedge clk) begin
        if (en) begin
            q1_reg      <= quad;
            rem1_reg    <= 24'(turn - base);
            st_reg[0].x <= gcdist_pkg::CORDIC_GAIN;
            st_reg[0].y <= '0;
            st_reg[0].z <= gcdist_pkg::cz_t'({1'b0, zprod[48:17]});
            q_reg[0]    <= q1_reg;
            for (int i = 0; i < N; i++) begin
                st_reg[i+1] <= rot_step(st_reg[i], i);
                q_reg[i+1]  <= q_reg[i];
            end
            sin_reg <= gcdist_pkg::clamp_unit(sn);
            cos_reg <= gcdist_pkg::clamp_unit(cn);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ----- sv/gcdist_hav.sv -----
module gcdist_hav (
    input  logic               clk,
    input  logic               en,
    input  gcdist_pkg::q30s_t  s_lat,
    input  gcdist_pkg::q30s_t  s_lon,
    input  gcdist_pkg::q30s_t  c_a,
    input  gcdist_pkg::q30s_t  c_b,
    output gcdist_pkg::q30u_t  a_q,
    output gcdist_pkg::q30u_t  b_q
);

    gcdist_pkg::q30s_t   hl_reg;
    gcdist_pkg::q30s_t   hs_reg;
    gcdist_pkg::q30s_t   cc_reg;
    gcdist_pkg::q30u_t   a_reg;
    gcdist_pkg::q30u_t   b_reg;
    logic signed [32:0]  sum;
    gcdist_pkg::q30u_t   a_next;

    always_comb begin
        sum = 33'(hs_reg) + 33'(gcdist_pkg::mulq(cc_reg, hl_reg));
        if (sum < 0) begin
            a_next = '0;
        end
        else if (sum > 33'(gcdist_pkg::ONE_Q30)) begin
            a_next = 31'(gcdist_pkg::ONE_Q30);
        end
        else begin
            a_next = 31'(sum);
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            hl_reg <= gcdist_pkg::mulq(s_lon, s_lon);
            hs_reg <= gcdist_pkg::mulq(s_lat, s_lat);
            cc_reg <= gcdist_pkg::mulq(c_a, c_b);
            a_reg  <= a_next;
            b_reg  <= 31'(gcdist_pkg::ONE_Q30) - a_next;
        end
    end

    assign a_q = a_reg;
    assign b_q = b_reg;

endmodule

// ----- sv/gcdist_sqrt.sv -----
module gcdist_sqrt (
    input  logic               clk,
    input  logic               en,
    input  gcdist_pkg::q30u_t  v,
    output gcdist_pkg::q30u_t  root
);

    localparam int N = gcdist_pkg::SQRT_STEPS;

    typedef struct packed {
        logic [60:0] rem;
        logic [61:0] res;
    } sq_t;

    // one result bit per stage
    function automatic sq_t sqrt_step(input sq_t s, input int k);
        logic [61:0] bitv;
        logic [61:0] trial;
        sq_t         o;
        bitv  = 62'd1 << (2 * (N - 1 - k));
        trial = s.res + bitv;
        if ({1'b0, s.rem} >= trial) begin
            o.rem = 61'({1'b0, s.rem} - trial);
            o.res = (s.res >> 1) + bitv;
        end
        else begin
            o.rem = s.rem;
            o.res = s.res >> 1;
        end
        return o;
    endfunction

    sq_t st_reg [0:N-1];
    sq_t first;

    always_comb begin
        first.rem = {v, 30'd0};
        first.res = '0;
    end

    always_ff @(posedge clk) begin
        if (en) begin
            st_reg[0] <= sqrt_step(first, 0);
            for (int k = 1; k < N; k++) begin
                st_reg[k] <= sqrt_step(st_reg[k-1], k);
            end
        end
    end

    assign root = st_reg[N-1].res[30:0];

endmodule

// ----- sv/gcdist_atan.sv -----
module gcdist_atan (
    input  logic               clk,
    input  logic               en,
    input  gcdist_pkg::q30u_t  y_in,
    input  gcdist_pkg::q30u_t  x_in,
    output logic [31:0]        angle2
);

    localparam int N    = gcdist_pkg::CORDIC_STEPS;
    localparam int ZMSB = gcdist_pkg::ZW - 1;

    function automatic gcdist_pkg::cordic_t vec_step(input gcdist_pkg::cordic_t s,
                                                     input int i);
        gcdist_pkg::cordic_t o;
        if (s.y > 0)
        begin
            o.x = s.x + (s.y >>> i);
            o.y = s.y - (s.x >>> i);
            o.z = s.z + gcdist_pkg::atan_entry(i);
        end
        else
        begin
            o.x = s.x - (s.y >>> i);
            o.y = s.y + (s.x >>> i);
            o.z = s.z - gcdist_pkg::atan_entry(i);
        end
        return o;
    endfunction

    gcdist_pkg::cordic_t st_reg [0:N-1];
    gcdist_pkg::cordic_t first;

    always_comb
    begin
        first.x = gcdist_pkg::cx_t'(x_in);
        first.y = gcdist_pkg::cx_t'(y_in);
        first.z = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= vec_step(first, 0);
            for (int i = 1; i < N; i++)
            begin
                st_reg[i] <= vec_step(st_reg[i-1], i);
            end
        end
    end

    // clamp at zero, then double for the central angle
    assign angle2 = st_reg[N-1].z[ZMSB] ? 32'd0 : {st_reg[N-1].z[30:0], 1'b0};

endmodule

// ----- sv/great_circle_distance.sv -----
// Throughput: one word per cycle; every stage moves on the same enable, which
// drops only while a finished word waits at the output.
// Reset: the valid line clears at once, radius_reg returns to 6371 km;
// data registers are not reset.
module great_circle_distance (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [21:0]         cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [23:0]  lat_a,
    input  logic signed [24:0]  lon_a,
    input  logic signed [23:0]  lat_b,
    input  logic signed [24:0]  lon_b,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [23:0]         distance
);

    localparam int D = gcdist_pkg::PIPE_DEPTH;

    logic                    en;
    logic [21:0]             radius_reg;
    logic [D-1:0]            valid_reg;
    gcdist_pkg::ang_t        dlat_reg;
    gcdist_pkg::ang_t        dlon_reg;
    gcdist_pkg::ang_t        la2_reg;
    gcdist_pkg::ang_t        lb2_reg;
    gcdist_pkg::q30s_t       s_lat;
    gcdist_pkg::q30s_t       s_lon;
    gcdist_pkg::q30s_t       c_a;
    gcdist_pkg::q30s_t       c_b;
    gcdist_pkg::q30u_t       hav_a;
    gcdist_pkg::q30u_t       hav_b;
    gcdist_pkg::q30u_t       root_a;
    gcdist_pkg::q30u_t       root_b;
    logic [31:0]             central;
    logic [53:0]             prod_reg;
    logic [54:0]             rounded;
    logic [23:0]             distance_reg;

    assign en       = out_ready || !valid_reg[D-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            radius_reg <= gcdist_pkg::RADIUS_RESET;
            valid_reg  <= '0;
        end
        else begin
            if (cfg_wr_en) begin
                radius_reg <= cfg_wr_data;
            end
            if (en) begin
                valid_reg <= {valid_reg[D-2:0], in_valid};
            end
        end
    end

    // latitudes doubled, raw differences already half angles
    always_ff @(posedge clk) begin
        if (en) begin
            dlat_reg <= gcdist_pkg::ang_t'(lat_b) - gcdist_pkg::ang_t'(lat_a);
            dlon_reg <= gcdist_pkg::ang_t'(lon_b) - gcdist_pkg::ang_t'(lon_a);
            la2_reg  <= gcdist_pkg::ang_t'(lat_a) <<< 1;
            lb2_reg  <= gcdist_pkg::ang_t'(lat_b) <<< 1;
        end
    end

    gcdist_sincos u_lat (.clk(clk), .en(en), .ang(dlat_reg), .sin_q(s_lat), .cos_q());
    gcdist_sincos u_lon (.clk(clk), .en(en), .ang(dlon_reg), .sin_q(s_lon), .cos_q());
    gcdist_sincos u_pa  (.clk(clk), .en(en), .ang(la2_reg),  .sin_q(),      .cos_q(c_a));
    gcdist_sincos u_pb  (.clk(clk), .en(en), .ang(lb2_reg),  .sin_q(),      .cos_q(c_b));

    gcdist_hav u_hav (
        .clk   (clk),
        .en    (en),
        .s_lat (s_lat),
        .s_lon (s_lon),
        .c_a   (c_a),
        .c_b   (c_b),
        .a_q   (hav_a),
        .b_q   (hav_b)
    );

    gcdist_sqrt u_sqrt_a (.clk(clk), .en(en), .v(hav_a), .root(root_a));
    gcdist_sqrt u_sqrt_b (.clk(clk), .en(en), .v(hav_b), .root(root_b));

    gcdist_atan u_atan (
        .clk    (clk),
        .en     (en),
        .y_in   (root_a),
        .x_in   (root_b),
        .angle2 (central)
    );

    assign rounded = 55'(prod_reg) + 55'd536870912;

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= 54'(radius_reg) * 54'(central);
            if (rounded[54] || rounded[53:30] == gcdist_pkg::DIST_MAX) begin
                distance_reg <= gcdist_pkg::DIST_MAX;
            end
            else begin
                distance_reg <= rounded[53:30];
            end
        end
    end

    assign out_valid = valid_reg[D-1];
    assign distance  = distance_reg;

endmodule

// ----- sv/gcdist_checker.sv -----
module gcdist_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [23:0]  distance
);

    // nothing comes out of reset holding a word
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // the pipe may only hold back input while a word waits
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while sink takes words");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance))
        else $error("output word lost or changed while stalled");

endmodule

bind great_circle_distance gcdist_checker u_gcdist_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .distance  (distance)
);

// ----- tb/sv/testbench.sv -----
module testbench;

    localparam longint LIMIT_CYCLES = 600000;
    localparam int     DRAIN_CYCLES = 120;
    localparam longint Q_ONE        = 64'sd1073741824;
    localparam longint Q_HALF       = 64'sd536870912;
    localparam longint TURN         = 64'sd47185920;
    localparam longint QTURN        = 64'sd11796480;
    localparam longint RAD_SCALE    = 64'sd18740330;
    localparam longint GAIN         = 64'sd652032875;
    localparam int     LAT_SPAN     = 5898240;
    localparam int     LON_SPAN     = 11796480;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [21:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    logic               out_valid;
    logic               out_ready;
    logic [23:0]        distance;

    logic [21:0]        radius_model;
    logic [23:0]        expected_dist[$];
    logic               quiet;
    int                 error_count;
    int                 words_sent;
    int                 words_checked;
    longint             cycle_count;

    great_circle_distance dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lat_a       (lat_a),
        .lon_a       (lon_a),
        .lat_b       (lat_b),
        .lon_b       (lon_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint atan_step(input int i);
        longint t[10];
        t = '{843314857, 497837829, 263043837, 133525159, 67021687,
              33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
        begin
            return t[i];
        end
        return longint'(1) << (30 - i);
    endfunction

    function automatic longint clip_unit(input longint v);
        if (v > Q_ONE)
        begin
            return Q_ONE;
        end
        if (v < -Q_ONE)
        begin
            return -Q_ONE;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + Q_HALF) >>> 30;
    endfunction

    // angle in 1/131072 degree, rotation CORDIC per quadrant
    task automatic rotate_angle(input longint ang, output longint sn, output longint cs);
        longint r, quad, rem, x, y, z, xn;
        r = ang % TURN;
        if (r < 0)
        begin
            r += TURN;
        end
        quad = r / QTURN;
        rem = r - quad * QTURN;
        z = (rem * RAD_SCALE + 65536) >>> 17;
        x = GAIN;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end
            else
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            x = xn;
        end
        case (quad)
            0: begin sn = y;  cs = x;  end
            1: begin sn = x;  cs = -y; end
            2: begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y; end
        endcase
        sn = clip_unit(sn);
        cs = clip_unit(cs);
    endtask

    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n)
        begin
            bit_v >>= 2;
        end
        while (bit_v != 0)
        begin
            if (n >= res + bit_v)
            begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, xn;
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (y > 0)
            begin
                xn = x + (y >>> i);
                y = y - (x >>> i);
                z += atan_step(i);
            end
            else
            begin
                xn = x - (y >>> i);
                y = y + (x >>> i);
                z -= atan_step(i);
            end
            x = xn;
        end
        return (z < 0) ? 0 : z;
    endfunction

    task automatic haversine_dist(input logic signed [23:0] la, input logic signed [24:0] oa,
                                  input logic signed [23:0] lb, input logic signed [24:0] ob,
                                  output logic [23:0] dist_out);
        longint s_lat, s_lon, c1, c2, unused, hav, ra, rb, arc;
        longint unsigned d;
        rotate_angle(longint'(lb) - longint'(la), s_lat, unused);
        rotate_angle(longint'(ob) - longint'(oa), s_lon, unused);
        rotate_angle(longint'(la) * 2, unused, c1);
        rotate_angle(longint'(lb) * 2, unused, c2);
        hav = qmul(s_lat, s_lat) + qmul(qmul(c1, c2), qmul(s_lon, s_lon));
        if (hav < 0)
        begin
            hav = 0;
        end
        if (hav > Q_ONE)
        begin
            hav = Q_ONE;
        end
        ra = floor_sqrt(longint'(hav) << 30);
        rb = floor_sqrt(longint'(Q_ONE - hav) << 30);
        arc = 2 * vector_angle(ra, rb);
        d = (longint'(radius_model) * arc + Q_HALF) >> 30;
        if (d > 64'd16777215)
        begin
            d = 64'd16777215;
        end
        dist_out = d[23:0];
    endtask

    task automatic report_mismatch(input logic [23:0] got, input logic [23:0] want);
        error_count++;
        $display("mismatch at cycle %0d: distance %0d, expected %0d", cycle_count, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dist.size() == 0)
            begin
                error_count++;
                $display("unexpected word at cycle %0d: distance %0d", cycle_count, distance);
            end
            else
            begin
                logic [23:0] want;
                want = expected_dist.pop_front();
                words_checked++;
                if (distance !== want)
                begin
                    report_mismatch(distance, want);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout with %0d words outstanding", expected_dist.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic signed [23:0] la, input logic signed [24:0] oa,
                             input logic signed [23:0] lb, input logic signed [24:0] ob);
        logic [23:0] want;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        lat_a <= la;
        lon_a <= oa;
        lat_b <= lb;
        lon_b <= ob;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        haversine_dist(la, oa, lb, ob, want);
        expected_dist.push_back(want);
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_dist.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(input logic [21:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        radius_model = value;
    endtask

    function automatic logic signed [23:0] rand_lat();
        return 24'(int'($urandom_range(0, 2 * LAT_SPAN)) - LAT_SPAN);
    endfunction

    function automatic logic signed [24:0] rand_lon();
        return 25'(int'($urandom_range(0, 2 * LON_SPAN)) - LON_SPAN);
    endfunction

    task automatic test_directed();
        send_word(0, 0, 0, 0);
        send_word(0, 0, 0, 25'(LON_SPAN));                      // antipodal on equator
        send_word(0, 25'(-LON_SPAN), 0, 25'(LON_SPAN));         // same point across the date line
        send_word(24'(LAT_SPAN), 0, 24'(-LAT_SPAN), 0);         // pole to pole
        send_word(24'(LAT_SPAN), 123456, 24'(LAT_SPAN), -654321); // both at a pole
        send_word(24'(-LAT_SPAN), 25'(-LON_SPAN), 24'(LAT_SPAN), 25'(LON_SPAN));
        send_word(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
        send_word(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
        send_word(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh7FFFFF, 25'sh0FFFFFF);
        send_word(3342336, 65536, 3342337, 65537);      // nearly equal points
        send_word(0, 0, 1, 0);
        send_word(1000000, 2000000, -1000000, -9796480);
        send_word(2949120, 0, -2949120, 25'(LON_SPAN)); // antipodes off equator
        send_word(-1, -1, 0, 0);
    endtask

    task automatic test_radius_settings();
        logic [21:0] settings[6];
        settings = '{22'd256, 22'd4194048, 22'h3FFFFF, 22'd0, 22'd1,
                     gcdist_pkg::RADIUS_RESET};
        foreach (settings[k])
        begin
            write_radius(settings[k]);
            repeat (6)
            begin
                send_word(rand_lat(), rand_lon(), rand_lat(), rand_lon());
            end
            send_word(0, 0, 0, 25'(LON_SPAN));
        end
    endtask

    task automatic random_words(input int count);
        logic signed [23:0] la, lb;
        logic signed [24:0] oa, ob;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    la = 24'($urandom);
                    oa = 25'($urandom);
                    lb = 24'($urandom);
                    ob = 25'($urandom);
                end
                1:
                begin
                    // short hops
                    la = rand_lat();
                    oa = rand_lon();
                    lb = la + 24'(int'($urandom_range(0, 20000)) - 10000);
                    ob = oa + 25'(int'($urandom_range(0, 20000)) - 10000);
                end
                2:
                begin
                    // close to antipodal, where a nears one
                    la = rand_lat();
                    oa = rand_lon();
                    lb = -la + 24'(int'($urandom_range(0, 2000)) - 1000);
                    ob = oa + 25'(LON_SPAN) + 25'(int'($urandom_range(0, 2000)) - 1000);
                end
                default:
                begin
                    la = rand_lat();
                    oa = rand_lon();
                    lb = rand_lat();
                    ob = rand_lon();
                end
            endcase
            send_word(la, oa, lb, ob);
        end
    endtask

    task automatic test_random();
        random_words(700);
        write_radius(22'($urandom_range(256, 4194048)));
        random_words(500);
        // sender holds off until the pipeline is empty
        wait_idle();
        write_radius(gcdist_pkg::RADIUS_RESET);
        random_words(300);
        quiet = 1'b1;
        random_words(300);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        lat_a = '0;
        lon_a = '0;
        lat_b = '0;
        lon_b = '0;
        quiet = 1'b0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        radius_model = gcdist_pkg::RADIUS_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_radius_settings();
        test_random();
        wait_idle();

        $display("%0d coordinate words sent, %0d distances checked, radius swept 0 to max",
                 words_sent, words_checked);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/gcdist_pkg.sv
sv/gcdist_sincos.sv
sv/gcdist_hav.sv
sv/gcdist_sqrt.sv
sv/gcdist_atan.sv
sv/great_circle_distance.sv
sv/gcdist_checker.sv
tb/sv/testbench.sv
